FILE: design/first_fit_heap_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// First-fit heap allocator - assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and fixed constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned SIZE_W    = 13;  // payload size and heap size
  localparam int unsigned OFF_W     = 12;  // payload offset
  localparam int unsigned WORD_W    = 14;  // header word: mark and size
  localparam int unsigned ALLOC_POS = 13;  // allocated mark in a header word
  localparam int unsigned POS_W     = 15;  // walk position and sums on it

  localparam int unsigned HEAP_RESET_BYTES = 4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  release_offset;
  } ffha_in_t;

  typedef struct packed {
    logic             granted;
    logic [OFF_W-1:0] payload_offset;
  } ffha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_TAIL,
    ST_DONE
  } ffha_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch the item, set the start position
    logic rd;        // read the header at the walk position
    logic claim;     // mark an exact fit allocated
    logic split;     // shrink the block, remember the tail
    logic tail;      // write the carved header
    logic rel_wr;    // clear the mark at the walk position
    logic res_free;  // result: granted, offset 0
    logic fail;      // result: refused
    logic adv;       // step to the next header
    logic push;      // move the result to the output register
  } ffha_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic free_ok;
    logic walk_ok;
    logic exact;
    logic split_fit;
    logic out_room;
  } ffha_sts_t;

endpackage

FILE: design/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Header store, walk position, heap size register and result registers.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int unsigned HEAP_LIMIT_BYTES = 4096,
  parameter int unsigned HEADER_BYTES     = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  ffha_pkg::ffha_in_t          in_data_i,
  input  ffha_pkg::ffha_ctl_t         ctl_i,
  output ffha_pkg::ffha_sts_t         sts_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output ffha_pkg::ffha_out_t         out_data_o
);
  import ffha_pkg::*;

  localparam int unsigned AW = (HEAP_LIMIT_BYTES > 1) ? $clog2(HEAP_LIMIT_BYTES) : 1;
  localparam int unsigned RST_HEAP =
    (HEAP_LIMIT_BYTES < HEAP_RESET_BYTES) ? HEAP_LIMIT_BYTES : HEAP_RESET_BYTES;
  localparam logic [POS_W-1:0]  HB_P       = POS_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HB_S       = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] RST_HEAP_S = SIZE_W'(RST_HEAP);
  localparam logic [SIZE_W-1:0] MIN_HEAP_S = SIZE_W'(HEADER_BYTES + 1);
  localparam logic [SIZE_W-1:0] MAX_HEAP_S = SIZE_W'(HEAP_LIMIT_BYTES);

  logic [WORD_W-1:0] mem [HEAP_LIMIT_BYTES];
  logic [WORD_W-1:0] mem_rd_q;
  logic              ovr_q;

  logic              cmd_q;
  logic [SIZE_W-1:0] want_q;
  logic [OFF_W-1:0]  rel_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  tail_q;
  logic [SIZE_W-1:0] heap_q;
  logic              fmt_q;
  ffha_out_t         res_q;
  logic              out_valid_q;
  ffha_out_t         out_q;

  logic [WORD_W-1:0] rd_word;
  logic              rd_alloc;
  logic [SIZE_W-1:0] rd_size;
  logic [POS_W-1:0]  need;
  logic [SIZE_W-1:0] new_size;
  logic [POS_W-1:0]  pos_hb;
  logic [POS_W-1:0]  tail_hb;
  logic              pos_in_lim;
  logic              tail_in_lim;
  logic [POS_W-1:0]  load_pos;
  logic [SIZE_W-1:0] cfg_sat;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // header at offset 0 reads as the formatted block until it is written
  assign rd_word  = ovr_q ? {1'b0, heap_q - HB_S} : mem_rd_q;
  assign rd_alloc = rd_word[ALLOC_POS];
  assign rd_size  = rd_word[SIZE_W-1:0];

  assign need        = POS_W'(want_q) + HB_P;
  assign new_size    = SIZE_W'(POS_W'(rd_size) - need);
  assign pos_hb      = pos_q + HB_P;
  assign tail_hb     = tail_q + HB_P;
  assign pos_in_lim  = 32'(pos_q) < 32'(HEAP_LIMIT_BYTES);
  assign tail_in_lim = 32'(tail_q) < 32'(HEAP_LIMIT_BYTES);

  assign load_pos = ((in_data_i.command == CMD_FREE) &&
                     (POS_W'(in_data_i.release_offset) >= HB_P)) ?
                    POS_W'(in_data_i.release_offset) - HB_P : '0;

  always_comb begin
    cfg_sat = cfg_wdata_i;
    if (32'(cfg_wdata_i) < 32'(HEADER_BYTES + 1)) begin
      cfg_sat = MIN_HEAP_S;
    end else if (32'(cfg_wdata_i) > 32'(HEAP_LIMIT_BYTES)) begin
      cfg_sat = MAX_HEAP_S;
    end
  end

  always_comb begin
    sts_o.is_free   = (cmd_q == CMD_FREE);
    sts_o.free_ok   = (POS_W'(rel_q) >= HB_P) && pos_in_lim;
    sts_o.walk_ok   = (pos_q < POS_W'(heap_q)) && pos_in_lim;
    sts_o.exact     = !rd_alloc && (rd_size == want_q);
    sts_o.split_fit = !rd_alloc && (POS_W'(rd_size) > need);
    sts_o.out_room  = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(pos_q);
    mem_wdata = rd_word;
    if (ctl_i.claim) begin
      mem_we    = 1'b1;
      mem_wdata = rd_word | WORD_W'(1 << ALLOC_POS);
    end else if (ctl_i.split) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b0, new_size};
    end else if (ctl_i.rel_wr) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b0, rd_size};
    end else if (ctl_i.tail) begin
      mem_we    = tail_in_lim;
      mem_waddr = AW'(tail_q);
      mem_wdata = {1'b1, want_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl_i.rd) begin
      mem_rd_q <= mem[AW'(pos_q)];
      ovr_q    <= fmt_q && (pos_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= RST_HEAP_S;
      fmt_q  <= 1'b1;
    end else if (cfg_we_i) begin
      heap_q <= cfg_sat;
      fmt_q  <= 1'b1;
    end else if (mem_we && (mem_waddr == '0)) begin
      fmt_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= in_data_i.command;
      want_q <= in_data_i.request_size;
      rel_q  <= in_data_i.release_offset;
      pos_q  <= load_pos;
    end else if (ctl_i.adv) begin
      pos_q  <= pos_hb + POS_W'(rd_size);
    end
    if (ctl_i.split) begin
      tail_q <= pos_hb + POS_W'(new_size);
    end
    if (ctl_i.claim) begin
      res_q <= '{granted: 1'b1, payload_offset: pos_hb[OFF_W-1:0]};
    end else if (ctl_i.tail) begin
      res_q <= '{granted: 1'b1, payload_offset: tail_hb[OFF_W-1:0]};
    end else if (ctl_i.res_free) begin
      res_q <= '{granted: 1'b1, payload_offset: '0};
    end else if (ctl_i.fail) begin
      res_q <= '{granted: 1'b0, payload_offset: '0};
    end
    if (ctl_i.push) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for the header walk, the free update and the result hand-off.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffha_pkg::ffha_sts_t sts_i,
  output ffha_pkg::ffha_ctl_t ctl_o
);
  import ffha_pkg::*;

  ffha_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.is_free) begin
          if (sts_i.free_ok) begin
            ctl_o.rd = 1'b1;
            state_d  = ST_EVAL;
          end else begin
            ctl_o.res_free = 1'b1;
            state_d        = ST_DONE;
          end
        end else if (sts_i.walk_ok) begin
          ctl_o.rd = 1'b1;
          state_d  = ST_EVAL;
        end else begin
          ctl_o.fail = 1'b1;
          state_d    = ST_DONE;
        end
      end
      ST_EVAL: begin
        if (sts_i.is_free) begin
          ctl_o.rel_wr   = 1'b1;
          ctl_o.res_free = 1'b1;
          state_d        = ST_DONE;
        end else if (sts_i.exact) begin
          ctl_o.claim = 1'b1;
          state_d     = ST_DONE;
        end else if (sts_i.split_fit) begin
          ctl_o.split = 1'b1;
          state_d     = ST_TAIL;
        end else begin
          ctl_o.adv = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_TAIL: begin
        ctl_o.tail = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_room) begin
          ctl_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/first_fit_heap_allocator_core.sv
// Requests are handled one at a time, paced by the header walk: a new request
//   is taken only after the previous result has moved to the output register.
// Reset: heap size 4096 (clipped to HEAP_LIMIT_BYTES), heap formatted as one
//   free block, no result pending; header memory contents are not cleared.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an implicit list of block headers kept in an
// on-chip header memory, one word per heap byte offset.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
  parameter int unsigned HEAP_LIMIT_BYTES = 4096,
  parameter int unsigned HEADER_BYTES     = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: heap size, writing it reformats the heap
  input  logic                        cfg_we_i,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ffha_pkg::ffha_in_t          in_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ffha_pkg::ffha_out_t         out_data_o
);
  import ffha_pkg::*;

  // Command and status between the sequencer and the datapath.
  ffha_ctl_t ctl;
  ffha_sts_t sts;

  // Sequencer: takes one request, then steps the walk. An allocation visits
  // headers from offset 0: each visit issues a registered read (CHECK) and
  // decides on the returned word (EVAL). An exact fit is marked allocated, a
  // larger block is shrunk and a new header written at its tail, anything
  // else advances by header plus payload. A free reads the header before the
  // given offset and writes it back with the mark cleared, or is granted at
  // once when that header lies outside the header memory. The result waits in
  // DONE until the output register can take it; the request side stays stalled.
  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath: header memory, walk position, heap size register with
  // saturation, and the output register. The header at offset 0 is
  // overridden by the formatted value after reset or a heap size write,
  // until the walk first writes it.
  ffha_dp #(
    .HEAP_LIMIT_BYTES (HEAP_LIMIT_BYTES),
    .HEADER_BYTES     (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_defines.svh"

module ffha_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ffha_pkg::ffha_out_t out_data_o
);
  import ffha_pkg::*;

  // hold a stalled result
  `FFHA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result dropped or changed")

  // a refused allocation carries no offset
  `FFHA_ASSERT_SAME(a_fail_zero, out_valid_o && !out_data_o.granted, out_data_o.payload_offset == '0, "refusal with non-zero offset")

  // one item at a time: stall right after a request transfer
  `FFHA_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o, "second request taken during work")

  // no result can appear in the cycle after a request transfer
  `FFHA_ASSERT_NEXT(a_no_early, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result too early")

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
